// ----- rtl/core/mck_pkg.sv -----
`default_nettype none

package mck_pkg;

    localparam int DOT_W   = 12;
    localparam int UNITS_W = 3;
    localparam int TICKS_W = 15;
    localparam int CHAR_W  = 8;
    localparam int PAT_W   = 8;
    localparam int IDX_W   = 7;
    localparam int ROM_DEPTH = 90;

    localparam logic [CHAR_W-1:0] SPACE_CODE = 8'd32;
    localparam logic [CHAR_W-1:0] FIRST_CODE = 8'd33;
    localparam logic [CHAR_W-1:0] LAST_CODE  = 8'd122;

    localparam logic [DOT_W-1:0] DOT_TICKS_RESET = 12'd60;

    // Segment lengths in dot units.
    localparam logic [UNITS_W-1:0] UNITS_NONE = 3'd0;
    localparam logic [UNITS_W-1:0] UNITS_DOT  = 3'd1;
    localparam logic [UNITS_W-1:0] UNITS_DASH = 3'd3;
    localparam logic [UNITS_W-1:0] UNITS_LGAP = 3'd3;
    localparam logic [UNITS_W-1:0] UNITS_WGAP = 3'd7;

    // Kind of character held by the sequencer.
    typedef enum logic [1:0] {
        KIND_SPACE,
        KIND_BAD,
        KIND_PATTERN
    } kind_t;

    // Patterns are read LSB first up to a sentinel one bit.
    localparam logic [PAT_W-1:0] PATTERN_ROM [ROM_DEPTH] = '{
        8'd107, 8'd82,  8'd1,   8'd137, 8'd1,   8'd40,  8'd94,  8'd109, 8'd109, 8'd1,
        8'd42,  8'd115, 8'd97,  8'd85,  8'd50,  8'd63,  8'd62,  8'd60,  8'd56,  8'd48,
        8'd32,  8'd33,  8'd35,  8'd39,  8'd47,  8'd120, 8'd53,  8'd1,   8'd49,  8'd1,
        8'd76,  8'd69,  8'd6,   8'd17,  8'd21,  8'd9,   8'd2,   8'd20,  8'd11,  8'd16,
        8'd4,   8'd30,  8'd13,  8'd18,  8'd7,   8'd5,   8'd15,  8'd22,  8'd27,  8'd10,
        8'd8,   8'd3,   8'd12,  8'd24,  8'd14,  8'd25,  8'd29,  8'd19,  8'd1,   8'd1,
        8'd1,   8'd1,   8'd77,  8'd94,  8'd6,   8'd17,  8'd21,  8'd9,   8'd2,   8'd20,
        8'd11,  8'd16,  8'd4,   8'd30,  8'd13,  8'd18,  8'd7,   8'd5,   8'd15,  8'd22,
        8'd27,  8'd10,  8'd8,   8'd3,   8'd12,  8'd24,  8'd14,  8'd25,  8'd29,  8'd19
    };

    function automatic logic [PAT_W-1:0] pattern_lookup(input logic [IDX_W-1:0] idx);
        logic [PAT_W-1:0] pat;
        pat = 8'd1;
        if (idx < IDX_W'(ROM_DEPTH))
        begin
            pat = PATTERN_ROM[idx];
        end
        return pat;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mck_ticks.sv -----
`default_nettype none

module mck_ticks
(
    input  wire logic [mck_pkg::UNITS_W-1:0] units,
    input  wire logic [mck_pkg::DOT_W-1:0]   dot_ticks,
    output logic      [mck_pkg::TICKS_W-1:0] ticks
);
    import mck_pkg::*;

    logic [TICKS_W-1:0] pp0;
    logic [TICKS_W-1:0] pp1;
    logic [TICKS_W-1:0] pp2;

    // Three shifted partial products of the dot length, one per unit bit.
    always_comb
    begin
        pp0 = units[0] ? {3'b000, dot_ticks}        : '0;
        pp1 = units[1] ? {2'b00, dot_ticks, 1'b0}   : '0;
        pp2 = units[2] ? {1'b0, dot_ticks, 2'b00}   : '0;
        ticks = pp0 + pp1 + pp2;
    end

endmodule

`default_nettype wire

// ----- rtl/core/morse_character_keyer.sv -----
`default_nettype none

// Once an item is taken, the sequencer holds it and then loads its first segment into the
// output register. One segment per cycle while the output side is ready; the single segment
// sequencer takes no new item until all segments (1 to 15) of a character are loaded.
// Reset (rst_n low, asynchronous) empties the sequencer and output register and sets
// dot_ticks to 60.
module morse_character_keyer
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [mck_pkg::CHAR_W-1:0] char_code,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             key_on,
    output logic      [mck_pkg::UNITS_W-1:0] segment_units,
    output logic      [mck_pkg::TICKS_W-1:0] segment_ticks,
    output logic             bad_char,
    output logic             last
);
    import mck_pkg::*;

    // Sequencer states.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    localparam logic REG_DOT_TICKS = 1'b0;

    // Configuration register. The only register is dot_ticks, selected by address
    // bit 2 low; any other word is ignored on write and reads as zero.
    logic [DOT_W-1:0] dot_ticks_reg;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_DOT_TICKS);
    assign prdata    = (paddr[2] == REG_DOT_TICKS) ? {20'd0, dot_ticks_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_ticks_reg <= DOT_TICKS_RESET;
        end
        else if (cfg_write)
        begin
            dot_ticks_reg <= pwdata[DOT_W-1:0];
        end
    end

    // Sequencer state. The pattern register is shifted right once per element;
    // the gap flag says that the silent unit after an element is due next.
    logic             state_reg;
    logic             state_next;
    kind_t            kind_reg;
    kind_t            kind_next;
    logic [PAT_W-1:0] pat_reg;
    logic [PAT_W-1:0] pat_next;
    logic             gap_reg;
    logic             gap_next;

    // Output register.
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               key_on_reg;
    logic [UNITS_W-1:0] units_reg;
    logic [TICKS_W-1:0] ticks_reg;
    logic               bad_reg;
    logic               last_reg;

    // The segment that the sequencer would present next.
    logic               seg_on;
    logic [UNITS_W-1:0] seg_units;
    logic [TICKS_W-1:0] seg_ticks;
    logic               seg_bad;
    logic               seg_last;
    logic               seg_load;
    logic               in_take;
    logic [CHAR_W-1:0]  char_off;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_take  = in_valid && in_ready;
    assign seg_load = (state_reg == ST_RUN) && (!out_valid_reg || out_ready);
    assign char_off = char_code - FIRST_CODE;

    always_comb
    begin
        seg_on    = 1'b0;
        seg_units = UNITS_NONE;
        seg_bad   = 1'b0;
        seg_last  = 1'b0;
        case (kind_reg)
            KIND_SPACE:
            begin
                seg_units = UNITS_WGAP;
                seg_last  = 1'b1;
            end
            KIND_BAD:
            begin
                seg_bad  = 1'b1;
                seg_last = 1'b1;
            end
            KIND_PATTERN:
            begin
                if (gap_reg)
                begin
                    seg_units = UNITS_DOT;
                end
                else if (pat_reg > PAT_W'(1))
                begin
                    seg_on    = 1'b1;
                    seg_units = pat_reg[0] ? UNITS_DASH : UNITS_DOT;
                end
                else
                begin
                    // Only the sentinel is left: close with the letter gap.
                    seg_units = UNITS_LGAP;
                    seg_last  = 1'b1;
                end
            end
            default:
            begin
                seg_bad  = 1'b1;
                seg_last = 1'b1;
            end
        endcase
    end

    mck_ticks u_ticks
    (
        .units     (seg_units),
        .dot_ticks (dot_ticks_reg),
        .ticks     (seg_ticks)
    );

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        pat_next       = pat_reg;
        gap_next       = gap_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (in_take)
        begin
            state_next = ST_RUN;
            gap_next   = 1'b0;
            pat_next   = pattern_lookup(char_off[IDX_W-1:0]);
            if (char_code == SPACE_CODE)
            begin
                kind_next = KIND_SPACE;
            end
            else if (char_code inside {[FIRST_CODE:LAST_CODE]})
            begin
                kind_next = KIND_PATTERN;
            end
            else
            begin
                kind_next = KIND_BAD;
            end
        end
        else if (seg_load)
        begin
            out_valid_next = 1'b1;
            if (seg_last)
            begin
                state_next = ST_IDLE;
            end
            else if (gap_reg)
            begin
                gap_next = 1'b0;
                pat_next = pat_reg >> 1;
            end
            else
            begin
                gap_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= KIND_BAD;
            pat_reg       <= '0;
            gap_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            pat_reg       <= pat_next;
            gap_reg       <= gap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Segment payload is held until taken, so it needs no reset.
    always_ff @(posedge clk)
    begin
        if (seg_load)
        begin
            key_on_reg <= seg_on;
            units_reg  <= seg_units;
            ticks_reg  <= seg_ticks;
            bad_reg    <= seg_bad;
            last_reg   <= seg_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign key_on        = key_on_reg;
    assign segment_units = units_reg;
    assign segment_ticks = ticks_reg;
    assign bad_char      = bad_reg;
    assign last          = last_reg;

`ifndef SYNTH
    // A rejected character gives one silent, empty, final segment.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_char) |-> (last && !key_on && segment_units == UNITS_NONE))
    else $error("rejected character segment malformed");

    // A key-down segment is always followed by its gap, so it is never the last.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && key_on) |-> !last)
    else $error("run ends on a key-down segment");

    // Once a character is taken, no other is taken until its run is closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while a run is in progress");

    // Leaving the busy state coincides with loading a final segment.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!in_ready ##1 in_ready) |-> (out_valid && last))
    else $error("sequencer returned to idle without a final segment");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/morse_character_keyer_test.sv -----
`default_nettype none

module morse_character_keyer_test;

    import mck_pkg::*;

    // One key segment as it leaves the block, in the block's own widths.
    typedef struct packed {
        logic               key_on;
        logic [UNITS_W-1:0] units;
        logic [TICKS_W-1:0] ticks;
        logic               bad;
        logic               last;
    } segment_t;

    // A directed row either sends a character, with its single segment typed in
    // or left to the predictor, or writes a register while the block is idle.
    typedef enum logic [1:0] {
        ROW_CHAR_TYPED,
        ROW_CHAR_PREDICTED,
        ROW_REG_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [2:0]        addr;
        logic [31:0]       data;
        logic [CHAR_W-1:0] chr;
        segment_t          seg;
    } dir_row_t;

    // Register map: one register per word.
    localparam int REG_DOT_TICKS = 0;
    localparam int REG_SPARE     = 1;
    localparam logic [2:0] ADDR_DOT_TICKS = 3'(4 * REG_DOT_TICKS);
    localparam logic [2:0] ADDR_SPARE     = 3'(4 * REG_SPARE);

    localparam int MAX_ELEMENTS = 7;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 32;
    localparam int LIMIT_CYCLES = 200000;

    // The keying patterns for '!' to 'z', read from the least significant bit
    // up to the marker one: a one is a dash and a zero is a dot.
    localparam logic [7:0] CODE_BOOK [90] = '{
        8'd107, 8'd82,  8'd1,   8'd137, 8'd1,   8'd40,  8'd94,  8'd109, 8'd109, 8'd1,
        8'd42,  8'd115, 8'd97,  8'd85,  8'd50,  8'd63,  8'd62,  8'd60,  8'd56,  8'd48,
        8'd32,  8'd33,  8'd35,  8'd39,  8'd47,  8'd120, 8'd53,  8'd1,   8'd49,  8'd1,
        8'd76,  8'd69,  8'd6,   8'd17,  8'd21,  8'd9,   8'd2,   8'd20,  8'd11,  8'd16,
        8'd4,   8'd30,  8'd13,  8'd18,  8'd7,   8'd5,   8'd15,  8'd22,  8'd27,  8'd10,
        8'd8,   8'd3,   8'd12,  8'd24,  8'd14,  8'd25,  8'd29,  8'd19,  8'd1,   8'd1,
        8'd1,   8'd1,   8'd77,  8'd94,  8'd6,   8'd17,  8'd21,  8'd9,   8'd2,   8'd20,
        8'd11,  8'd16,  8'd4,   8'd30,  8'd13,  8'd18,  8'd7,   8'd5,   8'd15,  8'd22,
        8'd27,  8'd10,  8'd8,   8'd3,   8'd12,  8'd24,  8'd14,  8'd25,  8'd29,  8'd19
    };

    localparam segment_t NO_SEG     = '0;
    localparam segment_t REJECT_SEG = '{1'b0, 3'd0, 15'd0, 1'b1, 1'b1};

    // The directed part. Rejected characters, the word space and the bare letter
    // gap are typed in; everything with a real pattern goes through the
    // predictor. After the reset length, the register rows cover the largest
    // length (with junk in the upper data bits), a write to the spare word that
    // must be ignored, a zero length and the smallest legal length.
    localparam int DIRECTED_ROWS = 28;
    localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_CHAR_TYPED,     3'd0, 32'd0, 8'd32,  '{1'b0, 3'd7, 15'd420, 1'b0, 1'b1}},
        '{ROW_CHAR_TYPED,     3'd0, 32'd0, 8'd0,   REJECT_SEG},
        '{ROW_CHAR_TYPED,     3'd0, 32'd0, 8'd31,  REJECT_SEG},
        '{ROW_CHAR_TYPED,     3'd0, 32'd0, 8'd123, REJECT_SEG},
        '{ROW_CHAR_TYPED,     3'd0, 32'd0, 8'd127, REJECT_SEG},
        '{ROW_CHAR_TYPED,     3'd0, 32'd0, 8'd128, REJECT_SEG},
        '{ROW_CHAR_TYPED,     3'd0, 32'd0, 8'd255, REJECT_SEG},
        '{ROW_CHAR_TYPED,     3'd0, 32'd0, 8'd35,  '{1'b0, 3'd3, 15'd180, 1'b0, 1'b1}},
        '{ROW_CHAR_PREDICTED, 3'd0, 32'd0, 8'd33,  NO_SEG},
        '{ROW_CHAR_PREDICTED, 3'd0, 32'd0, 8'd36,  NO_SEG},
        '{ROW_CHAR_PREDICTED, 3'd0, 32'd0, 8'd39,  NO_SEG},
        '{ROW_CHAR_PREDICTED, 3'd0, 32'd0, 8'd48,  NO_SEG},
        '{ROW_CHAR_PREDICTED, 3'd0, 32'd0, 8'd53,  NO_SEG},
        '{ROW_CHAR_PREDICTED, 3'd0, 32'd0, 8'd69,  NO_SEG},
        '{ROW_CHAR_PREDICTED, 3'd0, 32'd0, 8'd84,  NO_SEG},
        '{ROW_CHAR_PREDICTED, 3'd0, 32'd0, 8'd91,  NO_SEG},
        '{ROW_CHAR_PREDICTED, 3'd0, 32'd0, 8'd122, NO_SEG},
        '{ROW_REG_WRITE,      ADDR_DOT_TICKS, 32'hFFFF_FFFF, 8'd0, NO_SEG},
        '{ROW_CHAR_TYPED,     3'd0, 32'd0, 8'd32,  '{1'b0, 3'd7, 15'd28665, 1'b0, 1'b1}},
        '{ROW_CHAR_PREDICTED, 3'd0, 32'd0, 8'd36,  NO_SEG},
        '{ROW_REG_WRITE,      ADDR_SPARE, 32'd5, 8'd0, NO_SEG},
        '{ROW_CHAR_TYPED,     3'd0, 32'd0, 8'd35,  '{1'b0, 3'd3, 15'd12285, 1'b0, 1'b1}},
        '{ROW_REG_WRITE,      ADDR_DOT_TICKS, 32'd0, 8'd0, NO_SEG},
        '{ROW_CHAR_TYPED,     3'd0, 32'd0, 8'd32,  '{1'b0, 3'd7, 15'd0, 1'b0, 1'b1}},
        '{ROW_CHAR_PREDICTED, 3'd0, 32'd0, 8'd48,  NO_SEG},
        '{ROW_REG_WRITE,      ADDR_DOT_TICKS, 32'd1, 8'd0, NO_SEG},
        '{ROW_CHAR_TYPED,     3'd0, 32'd0, 8'd32,  '{1'b0, 3'd7, 15'd7, 1'b0, 1'b1}},
        '{ROW_CHAR_PREDICTED, 3'd0, 32'd0, 8'd97,  NO_SEG}
    };

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid;
    logic              in_ready;
    logic [CHAR_W-1:0] char_code;
    logic              out_valid;
    logic              out_ready;
    logic              key_on;
    logic [UNITS_W-1:0] segment_units;
    logic [TICKS_W-1:0] segment_ticks;
    logic              bad_char;
    logic              last;

    // The testbench's own copy of the dot length, kept in step with every write.
    logic [DOT_W-1:0] dot_len;

    // Segments still owed by the block, oldest first.
    segment_t expected_segments [$];
    segment_t due_seg;

    int error_count;
    int cycle_count;
    int sender_idle_pct;
    int stall_pct;
    int hold_left;
    bit hold_request;

    morse_character_keyer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .char_code     (char_code),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .key_on        (key_on),
        .segment_units (segment_units),
        .segment_ticks (segment_ticks),
        .bad_char      (bad_char),
        .last          (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Builds one segment; the tick count is the unit count times the dot
    // length, cut to the width of the port.
    function automatic segment_t make_segment(input logic on, input logic [UNITS_W-1:0] units,
                                              input logic bad, input logic fin);
        segment_t s;
        s.key_on = on;
        s.units  = units;
        s.ticks  = TICKS_W'(int'(units) * int'(dot_len));
        s.bad    = bad;
        s.last   = fin;
        return s;
    endfunction

    // Works out the whole run of segments that keys one character and queues it.
    task automatic predict_keying(input logic [CHAR_W-1:0] c);
        logic [7:0] pat;
        int         n;
        if (c == SPACE_CODE)
        begin
            expected_segments.push_back(make_segment(1'b0, UNITS_WGAP, 1'b0, 1'b1));
        end
        else if (c < FIRST_CODE || c > LAST_CODE)
        begin
            expected_segments.push_back(make_segment(1'b0, UNITS_NONE, 1'b1, 1'b1));
        end
        else
        begin
            pat = CODE_BOOK[int'(c) - int'(FIRST_CODE)];
            // Each element is its tone followed by one unit of silence; the
            // marker bit ends the pattern, and no pattern holds more than seven.
            for (n = 0; n < MAX_ELEMENTS && pat > 8'd1; n++)
            begin
                expected_segments.push_back(
                    make_segment(1'b1, pat[0] ? UNITS_DASH : UNITS_DOT, 1'b0, 1'b0));
                expected_segments.push_back(make_segment(1'b0, UNITS_DOT, 1'b0, 1'b0));
                pat = pat >> 1;
            end
            expected_segments.push_back(make_segment(1'b0, UNITS_LGAP, 1'b0, 1'b1));
        end
    endtask

    // Offers one character and holds it until the block takes it. The
    // expectation is queued at the edge of acceptance, which always comes
    // before the first segment of that character can appear.
    task automatic offer_char(input logic [CHAR_W-1:0] c, input row_kind_t kind,
                              input segment_t typed);
        in_valid  <= 1'b1;
        char_code <= c;
        do
            @(posedge clk);
        while (!in_ready);
        if (kind == ROW_CHAR_TYPED)
        begin
            expected_segments.push_back(typed);
        end
        else
        begin
            predict_keying(c);
        end
    endtask

    // Random gaps on the sending side, one decision per cycle.
    task automatic sender_pause();
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Lets the block run dry: every owed segment back, then a few spare cycles.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_segments.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // A write on the register port: a setup cycle, then an access cycle that
    // completes on the first edge with pready high.
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (int'(addr) / 4 == REG_DOT_TICKS)
        begin
            dot_len = data[DOT_W-1:0];
        end
    endtask

    // Mostly real characters with patterns, a fair share of word spaces, and
    // the rest drawn from the whole byte range so that rejects turn up too.
    function automatic logic [CHAR_W-1:0] random_char();
        int r;
        r = $urandom_range(99);
        if (r < 70)
        begin
            return CHAR_W'($urandom_range(int'(LAST_CODE), int'(FIRST_CODE)));
        end
        else if (r < 82)
        begin
            return SPACE_CODE;
        end
        return CHAR_W'($urandom_range(255, 0));
    endfunction

    task automatic run_phase(input int send_pct, input int recv_pct, input bit with_hold);
        int i;
        sender_idle_pct = send_pct;
        stall_pct       = recv_pct;
        // The long hold-off is counted by the receiving process itself; the
        // sender keeps going, so the block fills up and refuses further items.
        if (with_hold)
        begin
            hold_request = 1'b1;
        end
        for (i = 0; i < PHASE_ITEMS; i++)
        begin
            sender_pause();
            offer_char(random_char(), ROW_CHAR_PREDICTED, NO_SEG);
        end
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Receiving side: random stalls at the phase's rate, or the long hold-off
    // when one has been asked for.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_request || hold_left != 0)
        begin
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else
            begin
                hold_left--;
            end
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Every segment taken is compared, field by field, with the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_segments.size() == 0)
            begin
                $error("segment with nothing owed: key_on %0d units %0d ticks %0d bad %0d last %0d",
                       key_on, segment_units, segment_ticks, bad_char, last);
                error_count++;
            end
            else
            begin
                due_seg = expected_segments.pop_front();
                check_field("key_on", due_seg.key_on, key_on);
                check_field("segment_units", due_seg.units, segment_units);
                check_field("segment_ticks", due_seg.ticks, segment_ticks);
                check_field("bad_char", due_seg.bad, bad_char);
                check_field("last", due_seg.last, last);
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int i;
        clk             = 1'b0;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_valid        = 1'b0;
        char_code       = '0;
        out_ready       = 1'b0;
        dot_len         = DOT_TICKS_RESET;
        error_count     = 0;
        cycle_count     = 0;
        sender_idle_pct = 0;
        stall_pct       = 0;
        hold_left       = 0;
        hold_request    = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, back to back on both sides. Register rows wait for
        // the block to empty before writing.
        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (DIRECTED[i].kind == ROW_REG_WRITE)
            begin
                settle();
                reg_write(DIRECTED[i].addr, DIRECTED[i].data);
            end
            else
            begin
                offer_char(DIRECTED[i].chr, DIRECTED[i].kind, DIRECTED[i].seg);
            end
        end

        // Random part: each phase has its own dot length and its own idling.
        settle();
        reg_write(ADDR_DOT_TICKS, 32'(DOT_TICKS_RESET));
        run_phase(0, 0, 1'b0);

        settle();
        reg_write(ADDR_DOT_TICKS, 32'd4095);
        run_phase(56, 0, 1'b0);

        settle();
        reg_write(ADDR_DOT_TICKS, 32'($urandom_range(4094, 2)));
        run_phase(0, 56, 1'b0);

        settle();
        reg_write(ADDR_DOT_TICKS, 32'd0);
        run_phase(11, 11, 1'b0);

        settle();
        reg_write(ADDR_DOT_TICKS, 32'($urandom_range(4095, 1)));
        run_phase(0, 0, 1'b1);

        // Wait for every owed segment, then a few more cycles so that any
        // stray extra segment is caught.
        settle();

        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
